FILE: rtl/differential_drive_pid_steering_assert.svh
// Assertion macros for the differential-drive PID steering block.
// Each macro expands to one labeled concurrent assertion clocked by clock and
// disabled during reset; the including module must have those two signals.
`ifndef DIFFERENTIAL_DRIVE_PID_STEERING_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PID_STEERING_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define DDPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define DDPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ddps_pkg.sv
// Package for the differential-drive PID steering block.
// Holds widths, register indexes, reset values and the payload structs.
// No dependencies.
package ddps_pkg;

   localparam int SAMPLE_BITS    = 10;
   localparam int SPEED_BITS     = 8;
   localparam int GAIN_BITS      = 16;
   localparam int FRAC_BITS      = 12;
   localparam int INTEG_BITS     = 32;
   localparam int ERR_BITS       = SAMPLE_BITS + 1;
   localparam int DERIV_BITS     = SAMPLE_BITS + 2;
   localparam int PROD_P_BITS    = GAIN_BITS + ERR_BITS;
   localparam int PROD_I_BITS    = GAIN_BITS + INTEG_BITS;
   localparam int PROD_D_BITS    = GAIN_BITS + DERIV_BITS;
   localparam int SUM_BITS       = PROD_I_BITS + 2;
   localparam int CORR_BITS      = SUM_BITS - FRAC_BITS;
   localparam int SPD_CALC_BITS  = CORR_BITS + 1;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_P    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_I    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_D    = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED = CSR_INDEX_BITS'(3);

   localparam logic signed [GAIN_BITS-1:0] GAIN_P_RESET   = GAIN_BITS'(164);
   localparam logic signed [GAIN_BITS-1:0] GAIN_I_RESET   = GAIN_BITS'(0);
   localparam logic signed [GAIN_BITS-1:0] GAIN_D_RESET   = GAIN_BITS'(205);
   localparam logic [SPEED_BITS-1:0]       MAX_SPEED_RESET = SPEED_BITS'(250);

   localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
   localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left_inner_sample;
      logic [SAMPLE_BITS-1:0] right_inner_sample;
      logic [SPEED_BITS-1:0]  base_speed;
   } pid_req_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] left_motor_speed;
      logic [SPEED_BITS-1:0] right_motor_speed;
   } pid_rsp_type;

endpackage

FILE: rtl/differential_drive_pid_steering.sv
// PID steering for a differential-drive line follower: input, product and
// result registers, one sample pair per clock unless the response stalls.
// Depends on ddps_pkg and differential_drive_pid_steering_assert.svh.
`include "differential_drive_pid_steering_assert.svh"

// Each transfer on the request channel carries two inner line-sensor samples
// and a base speed; exactly one transfer follows on the response channel with
// the left and right motor speeds, in order. The block takes one request
// transfer per clock when the response side does not stall, and its result
// passes through the input, product and result registers. The error integral
// and the previous error are updated as an item leaves the input register;
// the three gain multiplies are registered into the product register then
// and summed from it into the result register. A stalled
// response holds in the result register while the earlier stages keep
// filling, so the request side stays ready until all three stages are full.
// The correction is Kp*e + Ki*integral + Kd*(e - previous e) with signed
// Q4.12 gains, truncated toward zero; each speed is clamped to 0..max_speed.
// The integral saturates at the signed 32-bit limits. Gains and max_speed are
// written through the csr port, which is always ready; writes to indexes
// beyond the four registers are ignored. Configuration should only change
// while no transfer is in flight.
module differential_drive_pid_steering (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ddps_pkg::pid_req_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ddps_pkg::pid_rsp_type                 rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ddps_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import ddps_pkg::*;

   // Configuration registers.
   logic signed [GAIN_BITS-1:0]  gain_p_ff;
   logic signed [GAIN_BITS-1:0]  gain_i_ff;
   logic signed [GAIN_BITS-1:0]  gain_d_ff;
   logic [SPEED_BITS-1:0]        max_speed_ff;

   // Controller state.
   logic signed [INTEG_BITS-1:0] integral_ff;
   logic signed [INTEG_BITS-1:0] integral_in;
   logic signed [ERR_BITS-1:0]   prior_error_ff;

   // Input stage.
   logic                         a_valid_ff;
   pid_req_type                  a_data_ff;

   // Product stage.
   logic                         b_valid_ff;
   logic signed [PROD_P_BITS-1:0] prod_p_ff;
   logic signed [PROD_I_BITS-1:0] prod_i_ff;
   logic signed [PROD_D_BITS-1:0] prod_d_ff;
   logic [SPEED_BITS-1:0]        base_b_ff;
   logic signed [PROD_P_BITS-1:0] prod_p_in;
   logic signed [PROD_I_BITS-1:0] prod_i_in;
   logic signed [PROD_D_BITS-1:0] prod_d_in;

   // Result stage.
   logic                         rsp_valid_ff;
   pid_rsp_type                  rsp_data_ff;
   pid_rsp_type                  rsp_data_in;

   // Handshake between stages.
   logic out_free;
   logic b_ready;
   logic b_move;
   logic a_move;
   logic req_take;

   // Arithmetic of the input stage.
   logic signed [ERR_BITS-1:0]   err_a;
   logic signed [DERIV_BITS-1:0] deriv_a;
   logic signed [INTEG_BITS:0]   integ_wide;

   // Arithmetic of the product stage.
   logic signed [SUM_BITS-1:0]   sum_b;
   logic signed [SUM_BITS-1:0]   sum_adj;
   logic signed [CORR_BITS-1:0]  corr_b;
   logic signed [SPD_CALC_BITS-1:0] base_ext;
   logic signed [SPD_CALC_BITS-1:0] left_raw;
   logic signed [SPD_CALC_BITS-1:0] right_raw;

   function automatic logic [SPEED_BITS-1:0] clamp_speed(
      input logic signed [SPD_CALC_BITS-1:0] value,
      input logic [SPEED_BITS-1:0]           top
   );
      logic signed [SPD_CALC_BITS-1:0] top_ext;
      logic [SPEED_BITS-1:0]           result;
      top_ext = $signed({{(SPD_CALC_BITS-SPEED_BITS){1'b0}}, top});
      priority if (value < 0) begin
         result = '0;
      end else if (value > top_ext) begin
         result = top;
      end else begin
         result = value[SPEED_BITS-1:0];
      end
      return result;
   endfunction

   // A stage advances when the stage after it is empty or emptying.
   // rsp_ready acts on the response register; earlier stages hold as it backs up.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b_move    = b_valid_ff && out_free;
   assign b_ready   = !b_valid_ff || out_free;
   assign a_move    = a_valid_ff && b_ready;
   assign req_ready = !a_valid_ff || b_ready;
   assign req_take  = req_valid && req_ready;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Error, saturating integral, derivative and the three gain products for the
   // item in the input register. The state only moves when that item moves on.
   always_comb begin
      err_a = $signed({1'b0, a_data_ff.left_inner_sample})
            - $signed({1'b0, a_data_ff.right_inner_sample});
      deriv_a = DERIV_BITS'(err_a) - DERIV_BITS'(prior_error_ff);
      integ_wide = (INTEG_BITS+1)'(integral_ff) + (INTEG_BITS+1)'(err_a);
      // Overflow shows as the two top bits of the widened sum disagreeing.
      if (integ_wide[INTEG_BITS] != integ_wide[INTEG_BITS-1]) begin
         integral_in = integ_wide[INTEG_BITS] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integral_in = integ_wide[INTEG_BITS-1:0];
      end
      prod_p_in = PROD_P_BITS'(gain_p_ff) * PROD_P_BITS'(err_a);
      prod_i_in = PROD_I_BITS'(gain_i_ff) * PROD_I_BITS'(integral_in);
      prod_d_in = PROD_D_BITS'(gain_d_ff) * PROD_D_BITS'(deriv_a);
   end

   // Sum of the three Q.12 products, truncated toward zero by biasing
   // negative sums before the shift, then the two clamped speeds.
   always_comb begin
      sum_b = SUM_BITS'(prod_p_ff) + SUM_BITS'(prod_i_ff) + SUM_BITS'(prod_d_ff);
      sum_adj = sum_b + $signed({{(SUM_BITS-FRAC_BITS){1'b0}},
                                 {FRAC_BITS{sum_b[SUM_BITS-1]}}});
      corr_b = sum_adj[SUM_BITS-1:FRAC_BITS];
      base_ext = $signed({{(SPD_CALC_BITS-SPEED_BITS){1'b0}}, base_b_ff});
      left_raw  = base_ext - SPD_CALC_BITS'(corr_b);
      right_raw = base_ext + SPD_CALC_BITS'(corr_b);
      rsp_data_in.left_motor_speed  = clamp_speed(left_raw, max_speed_ff);
      rsp_data_in.right_motor_speed = clamp_speed(right_raw, max_speed_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= GAIN_P_RESET;
         gain_i_ff      <= GAIN_I_RESET;
         gain_d_ff      <= GAIN_D_RESET;
         max_speed_ff   <= MAX_SPEED_RESET;
         integral_ff    <= '0;
         prior_error_ff <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GAIN_P) begin
               gain_p_ff <= csr_data[GAIN_BITS-1:0];
            end
            if (csr_index == CSR_GAIN_I) begin
               gain_i_ff <= csr_data[GAIN_BITS-1:0];
            end
            if (csr_index == CSR_GAIN_D) begin
               gain_d_ff <= csr_data[GAIN_BITS-1:0];
            end
            if (csr_index == CSR_MAX_SPEED) begin
               max_speed_ff <= csr_data[SPEED_BITS-1:0];
            end
         end

         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (req_take) begin
            a_data_ff <= req_data;
         end

         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (a_move) begin
            integral_ff    <= integral_in;
            prior_error_ff <= err_a;
            prod_p_ff      <= prod_p_in;
            prod_i_ff      <= prod_i_in;
            prod_d_ff      <= prod_d_in;
            base_b_ff      <= a_data_ff.base_speed;
         end

         if (out_free) begin
            rsp_valid_ff <= b_valid_ff;
         end
         if (b_move) begin
            rsp_data_ff <= rsp_data_in;
         end
      end
   end

   `DDPS_ASSERT_NOW(a_speed_clamped, rsp_valid_ff,
      (rsp_data_ff.left_motor_speed <= max_speed_ff) &&
      (rsp_data_ff.right_motor_speed <= max_speed_ff),
      "motor speed above max_speed")
   `DDPS_ASSERT_NEXT(a_integral_holds_top,
      a_move && (integral_ff == INTEG_MAX) && !err_a[ERR_BITS-1],
      integral_ff == INTEG_MAX,
      "integral left positive saturation on a non-negative error")
   `DDPS_ASSERT_NEXT(a_product_stage_kept, b_valid_ff && !out_free, b_valid_ff,
      "product stage dropped an item under stall")
   `DDPS_ASSERT_NOW(a_stall_means_full, !req_ready,
      a_valid_ff && b_valid_ff && rsp_valid_ff,
      "request stalled with an empty stage")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the differential-drive PID steering block.
// Drives sensor transfers, predicts the motor speeds and checks every response.
// Depends on ddps_pkg and the differential_drive_pid_steering RTL.
`timescale 1ns / 1ps

module tb;
   import ddps_pkg::*;

   localparam int     CYCLE_LIMIT     = 300000;
   localparam int     SETTLE_CYCLES   = 8;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     ITEMS_PER_PHASE = 106;
   localparam int     SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
   localparam int     SPEED_TOP       = (1 << SPEED_BITS) - 1;
   localparam longint Q_ONE           = longint'(1) << FRAC_BITS;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   pid_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   pid_rsp_type               rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   differential_drive_pid_steering dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns period: six nanoseconds low, then six high.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sensor items waiting to be driven, and the motor speeds that the accepted
   // items must produce, oldest first.
   pid_req_type sensor_items[$];
   pid_rsp_type expected_speeds[$];

   // Our own copy of the steering state and of the register file. The block
   // clears its state on reset, so these start from the reset values too.
   logic signed [GAIN_BITS-1:0]  gain_p_q      = GAIN_P_RESET;
   logic signed [GAIN_BITS-1:0]  gain_i_q      = GAIN_I_RESET;
   logic signed [GAIN_BITS-1:0]  gain_d_q      = GAIN_D_RESET;
   logic [SPEED_BITS-1:0]        max_speed_q   = MAX_SPEED_RESET;
   logic signed [INTEG_BITS-1:0] integral_q    = '0;
   logic signed [ERR_BITS-1:0]   prior_error_q = '0;

   // Transfers seen at the last rising edge; the falling-edge drivers use them.
   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;
   logic        csr_fire = 1'b0;

   int unsigned queued_count  = 0;
   int unsigned checked_count = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   int          req_gap   = 0;
   int          rsp_stall = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   pid_rsp_type want;

   // Clamp one motor speed to 0..max_speed.
   function automatic logic [SPEED_BITS-1:0] clamp_duty(longint speed);
      if (speed > longint'(max_speed_q))
         return max_speed_q;
      if (speed < 0)
         return '0;
      return speed[SPEED_BITS-1:0];
   endfunction

   // One control tick: error, saturating integral and derivative feed the
   // Q4.12 gains. The Q.12 sum is divided with truncation toward zero, which
   // is what SystemVerilog division of signed integers does.
   function automatic pid_rsp_type predict_motor_speeds(pid_req_type item);
      longint      err;
      longint      integ;
      longint      deriv;
      longint      sum;
      longint      corr;
      pid_rsp_type speeds;
      err   = longint'(item.left_inner_sample) - longint'(item.right_inner_sample);
      integ = longint'(integral_q) + err;
      if (integ > longint'(INTEG_MAX))
         integ = longint'(INTEG_MAX);
      if (integ < longint'(INTEG_MIN))
         integ = longint'(INTEG_MIN);
      deriv = err - longint'(prior_error_q);
      sum   = longint'(gain_p_q) * err + longint'(gain_i_q) * integ
            + longint'(gain_d_q) * deriv;
      corr  = sum / Q_ONE;
      integral_q    = integ[INTEG_BITS-1:0];
      prior_error_q = err[ERR_BITS-1:0];
      speeds.left_motor_speed  = clamp_duty(longint'(item.base_speed) - corr);
      speeds.right_motor_speed = clamp_duty(longint'(item.base_speed) + corr);
      return speeds;
   endfunction

   // Idle time drawn per item; a quiet side never waits.
   function automatic int pick_wait(bit quiet);
      if (quiet)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   // Samples outside the converter range are pulled back to its ends.
   function automatic void queue_item(int left, int right, int base);
      pid_req_type item;
      if (left < 0)
         left = 0;
      if (left > SAMPLE_TOP)
         left = SAMPLE_TOP;
      if (right < 0)
         right = 0;
      if (right > SAMPLE_TOP)
         right = SAMPLE_TOP;
      item.left_inner_sample  = SAMPLE_BITS'(left);
      item.right_inner_sample = SAMPLE_BITS'(right);
      item.base_speed         = SPEED_BITS'(base);
      sensor_items.push_back(item);
      queued_count++;
   endfunction

   function automatic int pick_edge(int top);
      case ($urandom_range(0, 2))
         0: return 0;
         1: return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   // Many items track the line closely, as a real follower does. Some keep a
   // steady offset so that the integral grows far, and the rest are wild.
   function automatic void queue_random_item(int drift);
      int left;
      int right;
      int base;
      right = $urandom_range(0, SAMPLE_TOP);
      base  = $urandom_range(0, SPEED_TOP);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: left = right + int'($urandom_range(0, 40)) - 20;
         4, 5:       left = right + drift + int'($urandom_range(0, 20)) - 10;
         6, 7:       left = $urandom_range(0, SAMPLE_TOP);
         default: begin
            left  = pick_edge(SAMPLE_TOP);
            right = pick_edge(SAMPLE_TOP);
            base  = pick_edge(SPEED_TOP);
         end
      endcase
      queue_item(left, right, base);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return '0;
         3, 4: return CSR_DATA_BITS'(int'($urandom_range(0, 8192)) - 4096);
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   // Register write over the csr channel. It starts and ends at a falling edge,
   // so back-to-back writes keep csr_valid high between them.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] reg_index,
                            logic [CSR_DATA_BITS-1:0] reg_value);
      csr_index = reg_index;
      csr_data  = reg_value;
      csr_valid = 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
   endtask

   // Every queued item has produced its response; let the pipeline settle
   // before the registers may change.
   task automatic wait_idle();
      while (checked_count < queued_count)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sampling side: everything that the block did at this edge is read here,
   // before any of its registers move.
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      rsp_fire <= rsp_valid && rsp_ready && !reset;
      csr_fire <= csr_valid && csr_ready && !reset;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_P:    gain_p_q    = csr_data;
               CSR_GAIN_I:    gain_i_q    = csr_data;
               CSR_GAIN_D:    gain_d_q    = csr_data;
               CSR_MAX_SPEED: max_speed_q = csr_data[SPEED_BITS-1:0];
               default: ;
            endcase
         end
         // The response of this edge belongs to an earlier request, so it is
         // checked before the request of this edge is predicted.
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (expected_speeds.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %0d/%0d", $time,
                        rsp_data.left_motor_speed, rsp_data.right_motor_speed);
               fail_count++;
            end else begin
               want = expected_speeds.pop_front();
               if (rsp_data.left_motor_speed !== want.left_motor_speed) begin
                  $display("%0t: left_motor_speed expected %0d, got %0d", $time,
                           want.left_motor_speed, rsp_data.left_motor_speed);
                  fail_count++;
               end
               if (rsp_data.right_motor_speed !== want.right_motor_speed) begin
                  $display("%0t: right_motor_speed expected %0d, got %0d", $time,
                           want.right_motor_speed, rsp_data.right_motor_speed);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_speeds.push_back(predict_motor_speeds(req_data));
      end
   end

   // Request driver. A pending item is held until its transfer; after each
   // transfer the next one waits a drawn number of cycles. Now and then the
   // driver switches between gappy and back-to-back stretches.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_fire) begin
            if ($urandom_range(0, 31) == 0)
               req_quiet = !req_quiet;
            req_gap = pick_wait(req_quiet);
         end
         if (req_gap == 0 && sensor_items.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= sensor_items.pop_front();
         end else begin
            req_valid <= 1'b0;
            if (req_gap > 0)
               req_gap--;
         end
      end
   end

   // Response back-pressure. Ready drops for a drawn number of cycles after
   // each transfer; the count runs whether or not a response is waiting, so
   // stalls land on every stage of the pipeline.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 31) == 0)
               rsp_quiet = !rsp_quiet;
            rsp_stall = pick_wait(rsp_quiet);
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus sequence: directed corners first, then random phases, each one
   // under its own register setting written while the block is idle.
   initial begin
      int drift;
      int phase;
      int n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset gains: converter extremes, balanced sensors and the base speed
      // at both ends.
      queue_item(0, 0, 0);
      queue_item(SAMPLE_TOP, 0, SPEED_TOP);
      queue_item(0, SAMPLE_TOP, SPEED_TOP);
      queue_item(SAMPLE_TOP, SAMPLE_TOP, SPEED_TOP);
      queue_item(0, 0, SPEED_TOP);
      queue_item(SAMPLE_TOP, 0, 0);
      queue_item(0, SAMPLE_TOP, 0);
      queue_item(512, 511, 128);
      queue_item(511, 512, 128);
      queue_item(341, 682, 200);
      wait_idle();

      // Extreme gains push the correction far past the speed range on both
      // sides. The upper byte of the max_speed write must be dropped, and
      // writes to indexes past the register file must change nothing.
      write_reg(CSR_GAIN_P, 16'h7FFF);
      write_reg(CSR_GAIN_I, 16'h8000);
      write_reg(CSR_GAIN_D, 16'h7FFF);
      write_reg(CSR_MAX_SPEED, 16'hA5FF);
      write_reg(CSR_INDEX_BITS'(4), 16'h0001);
      write_reg(CSR_INDEX_BITS'(255), 16'h0000);
      queue_item(SAMPLE_TOP, 0, 128);
      queue_item(0, SAMPLE_TOP, 128);
      queue_item(SAMPLE_TOP, 0, 128);
      queue_item(600, 600, SPEED_TOP);
      queue_item(0, 0, 0);
      wait_idle();

      // A zero speed limit forces both motors to stop whatever the error.
      write_reg(CSR_MAX_SPEED, 16'h5A00);
      queue_item(0, 0, SPEED_TOP);
      queue_item(SAMPLE_TOP, 0, 100);
      queue_item(0, SAMPLE_TOP, 100);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reg(CSR_GAIN_P, pick_gain());
         write_reg(CSR_GAIN_I, pick_gain());
         write_reg(CSR_GAIN_D, pick_gain());
         case ($urandom_range(0, 5))
            0: write_reg(CSR_MAX_SPEED, {8'($urandom), 8'd0});
            1, 2: write_reg(CSR_MAX_SPEED, {8'($urandom), 8'd255});
            default: write_reg(CSR_MAX_SPEED, CSR_DATA_BITS'($urandom));
         endcase
         write_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), CSR_DATA_BITS'($urandom));
         drift = (int'($urandom_range(0, 1)) * 2 - 1) * int'($urandom_range(50, 500));
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            queue_random_item(drift);
         wait_idle();
      end

      if (expected_speeds.size() != 0)
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_speeds.size());
      if (fail_count == 0 && expected_speeds.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
